>>> src/radix_to_ascii_digits_macros.svh
// assertion macros shared by the rtl files
`ifndef RADIX_TO_ASCII_DIGITS_MACROS_SVH
`define RADIX_TO_ASCII_DIGITS_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every edge outside reset
`define R2A_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define R2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define R2A_ASSERT_ALWAYS(lbl, expr, msg)
`define R2A_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/r2a_pkg.sv
`default_nettype none

package r2a_pkg;

    localparam int BASE_BITS  = 6;
    localparam int DIGIT_BITS = 6;
    localparam int CHAR_BITS  = 7;

    localparam logic [DIGIT_BITS-1:0] DEC_LIMIT  = 6'd10;
    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0]  ASCII_A    = 7'h41;
    localparam logic [CHAR_BITS-1:0]  CHAR_NONE  = 7'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } r2a_state_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic done;
        logic q_zero;
    } r2a_div_stat_t;

    // remainder to ascii
    function automatic logic [CHAR_BITS-1:0] to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d < DEC_LIMIT)
        begin
            return ASCII_ZERO + d_ext;
        end
        return ASCII_A + d_ext - {1'b0, DEC_LIMIT};
    endfunction

endpackage

`default_nettype wire

>>> src/r2a_ram.sv
`default_nettype none

module r2a_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/r2a_div.sv
`default_nettype none
`include "radix_to_ascii_digits_macros.svh"

module r2a_div
    import r2a_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [BASE_BITS-1:0]  divisor,
    output logic      [VALUE_BITS-1:0] quotient,
    output logic      [DIGIT_BITS-1:0] remainder,
    output r2a_div_stat_t              stat
);

    localparam int CW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [BASE_BITS-1:0]  div_reg, div_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIGIT_BITS:0]   trial;
    logic                  fits;

    // one quotient bit a cycle, restoring shift-subtract
    always_comb
    begin
        trial     = {rem_reg, q_reg[VALUE_BITS-1]};
        fits      = (trial >= {1'b0, div_reg});
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? DIGIT_BITS'(trial - {1'b0, div_reg}) : trial[DIGIT_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            q_reg    <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = q_reg;
    assign remainder   = rem_reg;
    assign stat.done   = done_reg;
    assign stat.q_zero = (q_reg == '0);

    `R2A_ASSERT_NEXT(a_div_finish, busy_reg && !start && cnt_reg == CW'(VALUE_BITS - 1), done_reg && !busy_reg, "divider did not finish after last step")
    `R2A_ASSERT_ALWAYS(a_div_done_idle, !(done_reg && busy_reg), "divider done while still busy")

endmodule

`default_nettype wire

>>> src/radix_to_ascii_digits.sv
// radix_to_ascii_digits: unsigned integer to ascii digits in a base from 2 to MAX_BASE
//
// input channel item_valid/item_ready carries value and base; only the low
// VALUE_BITS bits of value are used. output channel digit_valid/digit_ready carries
// one ascii digit per word, most significant first, last_digit on the final one.
// zero gives the single digit '0'. a base below 2 or above MAX_BASE gives one word
// with digit_char 0, last_digit 1 and bad_base 1.
// item_ready is high only while the block is idle: one item is worked on at a time.
// a conversion of n digits takes n divisions in the shared bit-serial divider, then
// for each digit the sequencer reads the digit store, loads the output register and
// presents the word. a stalled receiver simply holds the output register, nothing is
// lost. reset returns the sequencer to idle with no word pending; the digit store
// needs no clearing as every conversion writes its entries before reading them.

`default_nettype none
`include "radix_to_ascii_digits_macros.svh"

module radix_to_ascii_digits
    import r2a_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_BASE   = 36
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [63:0]          value,
    input  wire logic [BASE_BITS-1:0] base,
    output logic                      digit_valid,
    input  wire logic                 digit_ready,
    output logic      [CHAR_BITS-1:0] digit_char,
    output logic                      last_digit,
    output logic                      bad_base
);

    // digit store index width, one entry per possible digit
    localparam int AW = $clog2(VALUE_BITS);

    r2a_state_t state_reg, state_next;

    logic [AW-1:0]          addr_reg, addr_next;
    logic [BASE_BITS-1:0]   base_reg, base_next;
    logic [CHAR_BITS-1:0]   char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   bad_reg, bad_next;

    // divider hookup
    logic                   div_start;
    logic [VALUE_BITS-1:0]  div_dividend;
    logic [BASE_BITS-1:0]   div_divisor;
    logic [VALUE_BITS-1:0]  div_quotient;
    logic [DIGIT_BITS-1:0]  div_rem;
    r2a_div_stat_t          div_stat;

    // digit store hookup
    logic                   ram_we;
    logic [DIGIT_BITS-1:0]  ram_rdata;

    logic                   base_bad;

    assign base_bad = (base < BASE_BITS'(2)) || (base > BASE_BITS'(MAX_BASE));

    r2a_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .remainder(div_rem),
        .stat     (div_stat)
    );

    r2a_ram #(
        .WIDTH(DIGIT_BITS),
        .DEPTH(VALUE_BITS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(div_rem),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    // sequencer: divide until the quotient is zero, then read digits back downwards; a bad base sends the error word
    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        base_next    = base_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        bad_next     = bad_reg;
        div_start    = 1'b0;
        div_dividend = div_quotient;
        div_divisor  = base_reg;
        ram_we       = 1'b0;
        item_ready   = 1'b0;
        digit_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (base_bad)
                    begin
                        char_next  = CHAR_NONE;
                        last_next  = 1'b1;
                        bad_next   = 1'b1;
                        state_next = ST_SEND;
                    end
                    else
                    begin
                        // the first division starts on the base straight from the port
                        base_next    = base;
                        addr_next    = '0;
                        div_start    = 1'b1;
                        div_dividend = value[VALUE_BITS-1:0];
                        div_divisor  = base;
                        state_next   = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    ram_we = 1'b1;
                    if (div_stat.q_zero)
                    begin
                        // addr_reg now points at the most significant digit
                        state_next = ST_READ;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                char_next  = to_ascii(ram_rdata);
                last_next  = (addr_reg == '0);
                bad_next   = 1'b0;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                digit_valid = 1'b1;
                if (digit_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // base_reg is registered and reaches the divider only after start, so the first divisor is taken from the port
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        base_reg <= base_next;
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    assign digit_char = char_reg;
    assign last_digit = last_reg;
    assign bad_base   = bad_reg;

    `R2A_ASSERT_ALWAYS(a_no_overlap, !(item_ready && digit_valid), "input taken while a word is pending")
    `R2A_ASSERT_ALWAYS(a_bad_is_last, !(digit_valid && bad_base && !last_digit), "error word not marked last")
    `R2A_ASSERT_NEXT(a_idle_after_last, digit_valid && digit_ready && last_digit, item_ready, "block not idle after last word")

endmodule

`default_nettype wire
